// File: design/bmpdec_pkg.sv
package bmpdec_pkg;

    // Largest accepted absolute width or height
    localparam int MAX_DIM = 4096;

    localparam logic [15:0] BMP_SIGNATURE = 16'd19778;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;

    typedef enum logic [2:0] {
        KIND_PIXEL     = 3'd0,
        KIND_HEADER    = 3'd1,
        KIND_BAD_SIG   = 3'd2,
        KIND_BAD_DEPTH = 3'd3,
        KIND_TOO_LARGE = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row_index;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last;
    } t_out;

endpackage

// File: design/bmpdec_parser.sv
module bmpdec_parser
    import bmpdec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_data,
    output logic o_res_valid,
    output t_out o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } t_phase;

    localparam logic [5:0] OFS_WIDTH    = 6'd18;
    localparam logic [5:0] OFS_HEIGHT   = 6'd22;
    localparam logic [5:0] OFS_DEPTH    = 6'd28;
    localparam logic [5:0] IDX_SIG_CHK  = 6'd13;
    localparam logic [5:0] IDX_HDR_LAST = 6'd53;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_hc, n_hc;
    logic [15:0] r_sig, n_sig;
    logic [31:0] r_width_word, n_width_word;
    logic [31:0] r_height_word, n_height_word;
    logic [15:0] r_depth, n_depth;
    logic [12:0] r_width, n_width;
    logic [12:0] r_height, n_height;
    logic [12:0] r_col, n_col;
    logic [12:0] r_row, n_row;
    logic [1:0]  r_channel, n_channel;
    logic [7:0]  r_blue, n_blue;
    logic [7:0]  r_green, n_green;
    logic [1:0]  r_pad, n_pad;

    t_phase      ph;
    logic [5:0]  hc;
    logic [5:0]  w_off, h_off, d_off;
    logic [31:0] w_mag, h_mag;
    logic [12:0] col_next, row_next;

    assign w_mag = r_width_word[31] ? (~r_width_word + 32'd1) : r_width_word;
    assign h_mag = r_height_word[31] ? (~r_height_word + 32'd1) : r_height_word;

    always_comb begin
        n_phase       = r_phase;
        n_hc          = r_hc;
        n_sig         = r_sig;
        n_width_word  = r_width_word;
        n_height_word = r_height_word;
        n_depth       = r_depth;
        n_width       = r_width;
        n_height      = r_height;
        n_col         = r_col;
        n_row         = r_row;
        n_channel     = r_channel;
        n_blue        = r_blue;
        n_green       = r_green;
        n_pad         = r_pad;
        o_res_valid   = 1'b0;
        o_res         = '0;

        // a start byte is header byte zero of a fresh file
        ph       = i_data.file_start ? PH_HEADER : r_phase;
        hc       = i_data.file_start ? 6'd0 : r_hc;
        w_off    = hc - OFS_WIDTH;
        h_off    = hc - OFS_HEIGHT;
        d_off    = hc - OFS_DEPTH;
        col_next = r_col + 13'd1;
        row_next = r_row + 13'd1;

        if (i_fire) begin
            n_phase = ph;
            unique case (ph)
                PH_HEADER: begin
                    // every lane is rewritten before use, so no clearing is needed
                    if (hc < 6'd2)
                        n_sig[{hc[0], 3'b000} +: 8] = i_data.data_byte;
                    else if (hc >= OFS_WIDTH && hc < OFS_HEIGHT)
                        n_width_word[{w_off[1:0], 3'b000} +: 8] = i_data.data_byte;
                    else if (hc >= OFS_HEIGHT && hc < OFS_HEIGHT + 6'd4)
                        n_height_word[{h_off[1:0], 3'b000} +: 8] = i_data.data_byte;
                    else if (hc >= OFS_DEPTH && hc < OFS_DEPTH + 6'd2)
                        n_depth[{d_off[0], 3'b000} +: 8] = i_data.data_byte;
                    n_hc = hc + 6'd1;

                    if (hc == IDX_SIG_CHK && r_sig != BMP_SIGNATURE) begin
                        n_phase     = PH_DONE;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BAD_SIG;
                        o_res.last  = 1'b1;
                    end else if (hc == IDX_HDR_LAST) begin
                        o_res_valid = 1'b1;
                        if (r_depth != BMP_DEPTH) begin
                            n_phase    = PH_DONE;
                            o_res.kind = KIND_BAD_DEPTH;
                            o_res.last = 1'b1;
                        end else if (w_mag > 32'(MAX_DIM) || h_mag > 32'(MAX_DIM)) begin
                            n_phase    = PH_DONE;
                            o_res.kind = KIND_TOO_LARGE;
                            o_res.last = 1'b1;
                        end else begin
                            n_width            = w_mag[12:0];
                            n_height           = h_mag[12:0];
                            n_col              = '0;
                            n_row              = '0;
                            n_channel          = '0;
                            o_res.kind         = KIND_HEADER;
                            o_res.image_width  = w_mag[12:0];
                            o_res.image_height = h_mag[12:0];
                            if (w_mag == 32'd0 || h_mag == 32'd0) begin
                                n_phase    = PH_DONE;
                                o_res.last = 1'b1;
                            end else begin
                                n_phase = PH_PIXEL;
                            end
                        end
                    end
                end
                PH_PIXEL: begin
                    if (r_channel == 2'd0) begin
                        n_blue    = i_data.data_byte;
                        n_channel = 2'd1;
                    end else if (r_channel == 2'd1) begin
                        n_green   = i_data.data_byte;
                        n_channel = 2'd2;
                    end else begin
                        n_channel          = 2'd0;
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_PIXEL;
                        o_res.red          = i_data.data_byte;
                        o_res.green        = r_green;
                        o_res.blue         = r_blue;
                        o_res.column       = r_col[11:0];
                        o_res.row_index    = 12'(r_height - 13'd1 - r_row);
                        o_res.image_width  = r_width;
                        o_res.image_height = r_height;
                        n_col              = col_next;
                        if (col_next >= r_width) begin
                            n_col = '0;
                            n_row = row_next;
                            if (row_next >= r_height) begin
                                n_phase    = PH_DONE;
                                o_res.last = 1'b1;
                            end else begin
                                // (4 - 3w mod 4) mod 4 reduces to w mod 4
                                n_pad = r_width[1:0];
                                if (r_width[1:0] != 2'd0)
                                    n_phase = PH_PAD;
                            end
                        end
                    end
                end
                PH_PAD: begin
                    n_pad = r_pad - 2'd1;
                    if (r_pad == 2'd1)
                        n_phase = PH_PIXEL;
                end
                PH_IDLE, PH_DONE: begin
                    // drop bytes until the next file start
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hc      <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_channel <= '0;
            r_pad     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hc      <= n_hc;
            r_col     <= n_col;
            r_row     <= n_row;
            r_channel <= n_channel;
            r_pad     <= n_pad;
        end
        r_sig         <= n_sig;
        r_width_word  <= n_width_word;
        r_height_word <= n_height_word;
        r_depth       <= n_depth;
        r_width       <= n_width;
        r_height      <= n_height;
        r_blue        <= n_blue;
        r_green       <= n_green;
    end

endmodule

// File: design/bmpdec_out_buf.sv
module bmpdec_out_buf
    import bmpdec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_res,
    output logic o_space,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic [1:0] r_count, n_count;
    t_out       r_q0, n_q0;
    t_out       r_q1, n_q1;
    logic       pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_data  = r_q0;

    always_comb begin
        n_count = r_count;
        n_q0    = r_q0;
        n_q1    = r_q1;
        if (pop && i_push) begin
            // head leaves, new transaction joins at the tail
            if (r_count == 2'd1) begin
                n_q0 = i_res;
            end else begin
                n_q0 = r_q1;
                n_q1 = i_res;
            end
        end else if (pop) begin
            n_q0    = r_q1;
            n_count = r_count - 2'd1;
        end else if (i_push) begin
            if (r_count == 2'd0)
                n_q0 = i_res;
            else
                n_q1 = i_res;
            n_count = r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// File: design/bmp24_stream_decoder.sv
// Streaming decoder for uncompressed 24-bit BMP files.
// Input channel (i_in_valid / o_in_ready / i_in_data): one file byte per
// transaction; set file_start on the first byte of each file. Bytes that
// arrive before a file start, or after the final result of a file, are dropped.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per
// transaction: a header-accepted or header-error record after byte 13 or 53,
// then one pixel per B,G,R triple, with row padding skipped and rows numbered
// top-down. last marks the final result of a file.
// Throughput: one byte per cycle while the output is taken. A byte is decoded
// in the cycle it is accepted and its result is registered in the output buffer.
// The results sit in a two-entry buffer; o_in_ready drops only while both
// entries are full, so a stalled receiver throttles the input without loss.
// Reset (i_rst_n low at a clock edge) empties the buffer and returns the parser
// to idle, where it waits for a file start.
module bmp24_stream_decoder
    import bmpdec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic fire;
    logic res_valid;
    t_out res;

    assign fire = i_in_valid && o_in_ready;

    bmpdec_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data      (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bmpdec_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && res_valid),
        .i_res   (res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// File: design/bmpdec_checker.sv
module bmpdec_checker
    import bmpdec_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // nothing comes out in the cycle after a reset edge
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_nonpixel_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_PIXEL |->
            o_out_data.red == 8'd0 && o_out_data.green == 8'd0 &&
            o_out_data.blue == 8'd0 && o_out_data.column == 12'd0 &&
            o_out_data.row_index == 12'd0)
        else $error("non-pixel result carries pixel data");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_BAD_SIG ||
            o_out_data.kind == KIND_BAD_DEPTH || o_out_data.kind == KIND_TOO_LARGE) |->
            o_out_data.last && o_out_data.image_width == 13'd0 &&
            o_out_data.image_height == 13'd0)
        else $error("header error not final or carries dimensions");

    a_pixel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_PIXEL |->
            {1'b0, o_out_data.column} < o_out_data.image_width &&
            {1'b0, o_out_data.row_index} < o_out_data.image_height)
        else $error("pixel position outside the image");

endmodule

bind bmp24_stream_decoder bmpdec_checker u_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bmpdec_pkg::*;

    localparam int HEADER_BYTES      = 54;
    localparam int FILE_HEADER_BYTES = 14;
    localparam int WIDTH_POS         = 18;
    localparam int HEIGHT_POS        = 22;
    localparam int DEPTH_POS         = 28;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES      = 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_PIXEL,
        ST_PAD,
        ST_DONE
    } t_dec_state;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    bit   idle_on   = 1'b1;
    bit   hold_req  = 1'b0;
    int   fail_count;
    int   byte_count;
    t_out decoded_q[$];

    // Decoder state mirrored on the testbench side
    t_dec_state  dec_state;
    int          hdr_count;
    logic [15:0] sig_word;
    logic [31:0] width_word;
    logic [31:0] height_word;
    logic [15:0] depth_word;
    int          col_count;
    int          row_count;
    int          chan;
    logic [7:0]  blue_hold;
    logic [7:0]  green_hold;
    int          pad_left;

    always #1 clk = ~clk;

    bmp24_stream_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    function automatic void clear_decoder();
        dec_state   = ST_IDLE;
        hdr_count   = 0;
        sig_word    = '0;
        width_word  = '0;
        height_word = '0;
        depth_word  = '0;
        col_count   = 0;
        row_count   = 0;
        chan        = 0;
        blue_hold   = '0;
        green_hold  = '0;
        pad_left    = 0;
    endfunction

    function automatic bit decode_byte(input t_in item, output t_out res);
        logic [31:0] w;
        logic [31:0] h;
        int          idx;
        res = '0;
        if (item.file_start) begin
            clear_decoder();
            dec_state = ST_HEADER;
        end
        case (dec_state)
            ST_HEADER: begin
                idx = hdr_count;
                if (idx < 2)
                    sig_word[8*idx +: 8] = item.data_byte;
                else if (idx >= WIDTH_POS && idx < WIDTH_POS + 4)
                    width_word[8*(idx-WIDTH_POS) +: 8] = item.data_byte;
                else if (idx >= HEIGHT_POS && idx < HEIGHT_POS + 4)
                    height_word[8*(idx-HEIGHT_POS) +: 8] = item.data_byte;
                else if (idx >= DEPTH_POS && idx < DEPTH_POS + 2)
                    depth_word[8*(idx-DEPTH_POS) +: 8] = item.data_byte;
                hdr_count = idx + 1;
                if (hdr_count == FILE_HEADER_BYTES && sig_word != BMP_SIGNATURE) begin
                    dec_state = ST_DONE;
                    res.kind  = KIND_BAD_SIG;
                    res.last  = 1'b1;
                    return 1'b1;
                end
                if (hdr_count == HEADER_BYTES) begin
                    // take the magnitude; -2^31 stays huge and fails the size check
                    w = width_word[31] ? -width_word : width_word;
                    h = height_word[31] ? -height_word : height_word;
                    dec_state = ST_DONE;
                    res.last  = 1'b1;
                    if (depth_word != BMP_DEPTH)
                        res.kind = KIND_BAD_DEPTH;
                    else if (w > MAX_DIM || h > MAX_DIM)
                        res.kind = KIND_TOO_LARGE;
                    else begin
                        res.kind         = KIND_HEADER;
                        res.image_width  = w[12:0];
                        res.image_height = h[12:0];
                        width_word       = w;
                        height_word      = h;
                        if (w != 0 && h != 0) begin
                            dec_state = ST_PIXEL;
                            res.last  = 1'b0;
                        end
                    end
                    return 1'b1;
                end
                return 1'b0;
            end
            ST_PIXEL: begin
                if (chan == 0) begin
                    blue_hold = item.data_byte;
                    chan      = 1;
                    return 1'b0;
                end
                if (chan == 1) begin
                    green_hold = item.data_byte;
                    chan       = 2;
                    return 1'b0;
                end
                chan             = 0;
                res.kind         = KIND_PIXEL;
                res.red          = item.data_byte;
                res.green        = green_hold;
                res.blue         = blue_hold;
                res.column       = 12'(col_count);
                res.row_index    = 12'(height_word - 1 - row_count);
                res.image_width  = width_word[12:0];
                res.image_height = height_word[12:0];
                col_count++;
                if (col_count >= width_word) begin
                    col_count = 0;
                    row_count++;
                    if (row_count >= height_word) begin
                        dec_state = ST_DONE;
                        res.last  = 1'b1;
                    end else begin
                        pad_left = (4 - (3 * width_word) % 4) % 4;
                        if (pad_left != 0)
                            dec_state = ST_PAD;
                    end
                end
                return 1'b1;
            end
            ST_PAD: begin
                pad_left--;
                if (pad_left == 0)
                    dec_state = ST_PIXEL;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(string name, logic [12:0] want, logic [12:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (decoded_q.size() == 0) begin
                $error("kind: expected no transaction, got %0d", out_data.kind);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                check_field("kind", want.kind, out_data.kind);
                check_field("red", want.red, out_data.red);
                check_field("green", want.green, out_data.green);
                check_field("blue", want.blue, out_data.blue);
                check_field("column", want.column, out_data.column);
                check_field("row_index", want.row_index, out_data.row_index);
                check_field("image_width", want.image_width, out_data.image_width);
                check_field("image_height", want.image_height, out_data.image_height);
                check_field("last", want.last, out_data.last);
            end
        end
    end

    // Receiver: random back-pressure bursts, plus one long hold on request
    initial begin : receiver
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Leaves valid high on return; callers that let time pass must drop it first
    task automatic send_byte(input logic [7:0] b, input logic start);
        t_in  item;
        t_out res;
        item.data_byte  = b;
        item.file_start = start;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        if (decode_byte(item, res))
            decoded_q = {decoded_q, res};
        byte_count++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (decoded_q.size() != 0);
    endtask

    task automatic send_header(input logic [15:0] sig, input logic [31:0] wd,
                               input logic [31:0] ht, input logic [15:0] depth,
                               input int n_sent = HEADER_BYTES);
        logic [7:0] hdr [HEADER_BYTES];
        foreach (hdr[k])
            hdr[k] = 8'($urandom);
        {hdr[1], hdr[0]} = sig;
        {hdr[WIDTH_POS+3], hdr[WIDTH_POS+2], hdr[WIDTH_POS+1], hdr[WIDTH_POS]} = wd;
        {hdr[HEIGHT_POS+3], hdr[HEIGHT_POS+2], hdr[HEIGHT_POS+1], hdr[HEIGHT_POS]} = ht;
        {hdr[DEPTH_POS+1], hdr[DEPTH_POS]} = depth;
        for (int k = 0; k < n_sent; k++)
            send_byte(hdr[k], k == 0);
    endtask

    // Pixel rows, each followed by its padding
    task automatic send_body(input int wd, input int rows);
        int pad;
        pad = (4 - (3 * wd) % 4) % 4;
        repeat (rows)
            repeat (3 * wd + pad)
                send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_noise(input int n);
        repeat (n)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_stray_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_noise(4);
    endtask

    task automatic test_bad_signature();
        send_header(16'hFFFF, 32'd2, 32'd2, BMP_DEPTH, FILE_HEADER_BYTES);
        send_header(16'h424D, 32'd2, 32'd2, BMP_DEPTH, FILE_HEADER_BYTES + 2);
    endtask

    task automatic test_header_errors();
        send_header(BMP_SIGNATURE, 32'd2, 32'd2, 16'd32);
        send_header(BMP_SIGNATURE, 32'(MAX_DIM + 1), 32'd1, BMP_DEPTH);
        send_header(BMP_SIGNATURE, 32'd1, 32'h8000_0000, BMP_DEPTH);
        send_noise(3);
    endtask

    task automatic test_empty_images();
        send_header(BMP_SIGNATURE, 32'd0, 32'd5, BMP_DEPTH);
        send_noise(4);
    endtask

    // The largest height is only started; the next file start cuts it off
    task automatic test_dimension_limits();
        send_header(BMP_SIGNATURE, 32'd1, 32'(MAX_DIM), BMP_DEPTH);
        send_body(1, 2);
    endtask

    task automatic test_row_padding();
        send_header(BMP_SIGNATURE, 32'(-3), 32'(-2), BMP_DEPTH);
        send_body(3, 2);
    endtask

    task automatic test_restart();
        send_header(BMP_SIGNATURE, 32'd2, 32'd2, BMP_DEPTH);
        send_body(2, 1);
        send_noise(2);
        send_header(BMP_SIGNATURE, 32'd3, 32'd3, BMP_DEPTH, 20);
    endtask

    // Hold the receiver off while pixels keep coming, then let everything drain
    task automatic test_output_stall();
        hold_req = 1'b1;
        send_header(BMP_SIGNATURE, 32'd2, 32'd2, BMP_DEPTH);
        send_body(2, 2);
        wait_drain();
    endtask

    task automatic test_random_files();
        int first;
        int wd;
        int ht;
        first = byte_count;
        while (byte_count - first < RANDOM_BYTES) begin
            wd = $urandom_range(1, 7);
            ht = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_header(BMP_SIGNATURE, $urandom_range(0, 1) ? 32'(-wd) : 32'(wd),
                                $urandom_range(0, 1) ? 32'(-ht) : 32'(ht), BMP_DEPTH);
                    send_body(wd, ht);
                    send_noise($urandom_range(0, 3));
                end
                6: begin
                    send_header(BMP_SIGNATURE, 32'(wd), 32'(ht), BMP_DEPTH);
                    send_body(wd, $urandom_range(0, ht - 1));
                    send_noise($urandom_range(0, 3 * wd));
                end
                7: begin
                    case ($urandom_range(0, 3))
                        0: send_header(16'($urandom), 32'(wd), 32'(ht), BMP_DEPTH,
                                       FILE_HEADER_BYTES);
                        1: send_header(BMP_SIGNATURE, 32'(wd), 32'(ht), 16'($urandom));
                        2: send_header(BMP_SIGNATURE, $urandom, $urandom, BMP_DEPTH);
                        default: send_header(BMP_SIGNATURE, $urandom_range(0, 1) ? 32'd0 : 32'(wd),
                                             32'd0, BMP_DEPTH);
                    endcase
                    send_noise($urandom_range(0, 4));
                end
                8: send_header(BMP_SIGNATURE, 32'(wd), 32'(ht), BMP_DEPTH,
                               $urandom_range(1, HEADER_BYTES - 1));
                default: begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                end
            endcase
            if ($urandom_range(0, 19) == 0)
                wait_drain();
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_header(BMP_SIGNATURE, 32'd2, 32'(-2), BMP_DEPTH);
        send_body(2, 2);
    endtask

    initial begin
        clear_decoder();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_stray_bytes();
        test_bad_signature();
        test_header_errors();
        test_empty_images();
        test_dimension_limits();
        test_row_padding();
        test_restart();
        test_output_stall();
        test_random_files();
        test_steady_stream();
        wait_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
